// ===== rtl/core/grsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grsm_pkg
// Shared types, sizes and helpers for the gated residual slot mixer.
// ----------------------------------------------------------------------------
package grsm_pkg;

   localparam int N_SLOTS     = 4;
   localparam int DIM         = 256;
   localparam int GATE_REGS   = 4;

   localparam int DATA_W      = 16;
   localparam int IDX_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int FRAC_SHIFT  = 12;
   localparam int MUL_W       = 2 * DATA_W;
   localparam int PROD_W      = MUL_W - FRAC_SHIFT;
   localparam int ACC_W       = PROD_W + 4;

   localparam int STORE_DEPTH = N_SLOTS * DIM;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SLOT_W      = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
   localparam int GSEL_W      = $clog2(GATE_REGS);

   // Q12.20 product plus half an LSB of Q8.8
   localparam logic signed [MUL_W-1:0] ROUND_BIAS = MUL_W'(1 << (FRAC_SHIFT - 1));

   // Register map: read gates first, then write gates
   localparam logic [CSR_IDX_W-1:0] CSR_READ_GATE_0  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_GATE_0 = CSR_IDX_W'(GATE_REGS);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   // Clamp a wide signed sum to the 16-bit Q8.8 range
   function automatic data_type sat16(input acc_type v);
      data_type r;
      if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
         r = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/grsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grsm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grsm_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grsm_mul
// Shared Q8.8 x Q4.12 multiplier: registered product, rounded back to Q12.8.
// ----------------------------------------------------------------------------
module grsm_mul (
   input  logic               clock,
   input  grsm_pkg::data_type a,
   input  grsm_pkg::data_type b,
   output grsm_pkg::prod_type rnd
);
   import grsm_pkg::*;

   logic signed [MUL_W-1:0] prod_ff;
   logic signed [MUL_W-1:0] prod_in;
   logic signed [MUL_W-1:0] biased;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round half up, then floor shift back to Q12.8
   assign biased = prod_ff + ROUND_BIAS;
   assign rnd    = biased[FRAC_SHIFT +: PROD_W];

endmodule

// ===== rtl/core/gated_residual_slot_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_residual_slot_mixer
// Gated residual mixing of one element against a store of slot vectors.
// ----------------------------------------------------------------------------
// Holds N_SLOTS vectors of DIM Q8.8 elements in one RAM, one entry per slot
// and element. A read item (opcode 0) returns value plus the sum of read gate
// times the stored element over all slots, saturated to 16 bits; a write item
// (opcode 1) stores the saturated product write gate times value in every
// slot whose write gate is nonzero and returns nothing. All products go
// through a single shared 16x16 multiplier, one slot per cycle, and the RAM
// has one read port, so the block works on one item at a time and takes no
// new item until the last one is done. After reset the store is cleared one
// entry per cycle while req_ready stays low; gate registers can be written
// throughout. Gate registers may only be changed while the block is idle.
// ----------------------------------------------------------------------------
module gated_residual_slot_mixer (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [grsm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  grsm_pkg::data_type                   csr_data,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  grsm_pkg::opcode_type                 req_opcode,
   input  logic [grsm_pkg::IDX_W-1:0]           req_element_index,
   input  grsm_pkg::data_type                   req_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output grsm_pkg::data_type                   rsp_mixed_value,
   output logic                                 rsp_all_gates_zero
);
   import grsm_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(N_SLOTS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] DIM_STEP  = ADDR_W'(DIM);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   data_type          read_gate_ff  [N_SLOTS];
   data_type          read_gate_in  [N_SLOTS];
   data_type          write_gate_ff [N_SLOTS];
   data_type          write_gate_in [N_SLOTS];

   // item context
   opcode_type        op_ff, op_in;
   data_type          val_ff, val_in;
   logic              inr_ff, inr_in;

   // issue stage
   logic              issue_ff, issue_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // RAM data / write-back stage
   logic              s1_v_ff, s1_v_in;
   logic              s1_last_ff, s1_last_in;
   logic [SLOT_W-1:0] s1_slot_ff, s1_slot_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic              s1_wen_ff, s1_wen_in;

   // accumulate stage
   logic              s2_v_ff, s2_v_in;
   logic              s2_last_ff, s2_last_in;
   acc_type           acc_ff, acc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   data_type          rsp_mixed_ff, rsp_mixed_in;
   logic              rsp_agz_ff, rsp_agz_in;

   logic              gates_zero;
   logic              csr_slot_ok;
   logic [SLOT_W-1:0] csr_slot;
   data_type          ram_rdata;
   logic              ram_wen;
   logic [ADDR_W-1:0] ram_waddr;
   data_type          ram_wdata;
   logic              ram_ren;
   data_type          mul_a;
   data_type          mul_b;
   prod_type          mul_rnd;
   data_type          store_val;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      gates_zero = 1'b1;
      for (int s = 0; s < N_SLOTS; s++) begin
         if ((read_gate_ff[s] != '0) || (write_gate_ff[s] != '0)) begin
            gates_zero = 1'b0;
         end
      end
   end

   // shared multiplier: write items scale value, read items scale RAM data
   assign mul_a = (op_ff == OP_WRITE) ? val_ff : (inr_ff ? ram_rdata : '0);
   assign mul_b = (op_ff == OP_WRITE) ? write_gate_ff[cnt_ff] : read_gate_ff[s1_slot_ff];

   grsm_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .rnd   (mul_rnd)
   );

   assign store_val = sat16(ACC_W'(mul_rnd));

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wen   = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_wen   = (state_ff == ST_RUN) && (op_ff == OP_WRITE) && s1_v_ff && s1_wen_ff;
         ram_waddr = s1_addr_ff;
         ram_wdata = store_val;
      end
   end

   assign ram_ren = (state_ff == ST_RUN) && (op_ff == OP_READ) && issue_ff;

   grsm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_ren),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign csr_slot    = SLOT_W'(csr_index[GSEL_W-1:0]);
   assign csr_slot_ok = int'(csr_index[GSEL_W-1:0]) < N_SLOTS;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      read_gate_in  = read_gate_ff;
      write_gate_in = write_gate_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      inr_in        = inr_ff;
      issue_in      = issue_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      s1_v_in       = 1'b0;
      s1_last_in    = s1_last_ff;
      s1_slot_in    = s1_slot_ff;
      s1_addr_in    = s1_addr_ff;
      s1_wen_in     = s1_wen_ff;
      s2_v_in       = s1_v_ff && (op_ff == OP_READ);
      s2_last_in    = s1_last_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_mixed_in  = rsp_mixed_ff;
      rsp_agz_in    = rsp_agz_ff;

      // gate registers; slots beyond N_SLOTS stay zero
      if (csr_valid && csr_slot_ok) begin
         if (csr_index < CSR_WRITE_GATE_0) begin
            read_gate_in[csr_slot] = csr_data;
         end else begin
            write_gate_in[csr_slot] = csr_data;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               val_in   = req_value;
               inr_in   = int'(req_element_index) < DIM;
               issue_in = 1'b1;
               cnt_in   = '0;
               addr_in  = ADDR_W'(req_element_index);
               acc_in   = ACC_W'(req_value);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // one slot per cycle into the shared multiplier
            if (issue_ff) begin
               s1_v_in    = 1'b1;
               s1_last_in = (cnt_ff == LAST_SLOT);
               s1_slot_in = cnt_ff;
               s1_addr_in = addr_ff;
               s1_wen_in  = inr_ff && (write_gate_ff[cnt_ff] != '0);
               cnt_in     = cnt_ff + SLOT_W'(1);
               addr_in    = addr_ff + DIM_STEP;
               if (cnt_ff == LAST_SLOT) begin
                  issue_in = 1'b0;
               end
            end
            if (op_ff == OP_WRITE) begin
               if (s1_v_ff && s1_last_ff) begin
                  state_in = ST_IDLE;
               end
            end else if (s2_v_ff) begin
               acc_in = acc_ff + ACC_W'(mul_rnd);
               if (s2_last_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hold the sum until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mixed_in = sat16(acc_ff);
               rsp_agz_in   = gates_zero;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < N_SLOTS; s++) begin
            read_gate_ff[s]  <= '0;
            write_gate_ff[s] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         issue_ff      <= issue_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         rsp_valid_ff  <= rsp_valid_in;
         read_gate_ff  <= read_gate_in;
         write_gate_ff <= write_gate_in;
      end
      op_ff        <= op_in;
      val_ff       <= val_in;
      inr_ff       <= inr_in;
      cnt_ff       <= cnt_in;
      addr_ff      <= addr_in;
      s1_last_ff   <= s1_last_in;
      s1_slot_ff   <= s1_slot_in;
      s1_addr_ff   <= s1_addr_in;
      s1_wen_ff    <= s1_wen_in;
      s2_last_ff   <= s2_last_in;
      acc_ff       <= acc_in;
      rsp_mixed_ff <= rsp_mixed_in;
      rsp_agz_ff   <= rsp_agz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mixed_value    = rsp_mixed_ff;
   assign rsp_all_gates_zero = rsp_agz_ff;

endmodule

// ===== rtl/core/grsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grsm_checker
// Port-level checks for the gated residual slot mixer, bound to the top level.
// ----------------------------------------------------------------------------
module grsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input grsm_pkg::data_type rsp_mixed_value,
   input logic               rsp_all_gates_zero
);

   // store clearing keeps the input closed right after reset
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one item at a time: an accepted item closes the input
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after an item was accepted");

   // no result can appear in the cycle after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result raised too early after an accepted item");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_mixed_value) && $stable(rsp_all_gates_zero)))
      else $error("stalled result dropped or changed");

endmodule

bind gated_residual_slot_mixer grsm_checker u_grsm_checker (.*);
